// ----- hdl/hpd_pkg.sv -----
// ============================================================================
// hpd_pkg: shared types and constants of the hall pulse detector
// Field widths, register indexes, opcodes and reset values of the
// configuration registers.
// ============================================================================
`default_nettype none

package hpd_pkg;

   // Fixed field widths of the channels and registers
   localparam int OPCODE_W    = 1;
   localparam int ADC_FIELD_W = 10;
   localparam int TIME_W      = 32;
   localparam int THRESH_W    = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Fractional bits of the baseline
   localparam int FRAC_W = 8;

   // Parameter defaults
   localparam int TRACK_DIVISOR_DEF = 16;
   localparam int ADC_BITS_DEF      = 10;

   // Configuration reset values
   localparam logic [THRESH_W-1:0] TRIGGER_DELTA_RST   = THRESH_W'(100);
   localparam logic [THRESH_W-1:0] RELEASE_DELTA_RST   = THRESH_W'(50);
   localparam logic [TIME_W-1:0]   MIN_INTERVAL_RST    = TIME_W'(10000);
   localparam logic [TIME_W-1:0]   SAMPLE_PERIOD_RST   = TIME_W'(1000);

   typedef enum logic [OPCODE_W-1:0] {
      OP_SAMPLE  = 1'b0,
      OP_RESTART = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_DELTA  = 2'd0,
      CSR_RELEASE_DELTA  = 2'd1,
      CSR_MIN_INTERVAL   = 2'd2,
      CSR_SAMPLE_PERIOD  = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hdl/hpd_req_if.sv -----
// ============================================================================
// hpd_req_if: input channel of the hall pulse detector
// One beat carries an opcode, an averaged ADC sample and the current time.
// ============================================================================
`default_nettype none

interface hpd_req_if import hpd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   opcode_type              opcode;
   logic [ADC_FIELD_W-1:0]  adc_sample;
   logic [TIME_W-1:0]       time_us;

   modport source (output valid, output opcode, output adc_sample, output time_us,
                   input ready);
   modport sink   (input valid, input opcode, input adc_sample, input time_us,
                   output ready);
endinterface

`default_nettype wire

// ----- hdl/hpd_rsp_if.sv -----
// ============================================================================
// hpd_rsp_if: result channel of the hall pulse detector
// One beat reports the detector state after one input beat.
// ============================================================================
`default_nettype none

interface hpd_rsp_if import hpd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    sample_taken;
   logic                    pulse_seen;
   logic [TIME_W-1:0]       pulse_total;
   logic [TIME_W-1:0]       pulse_period_us;
   logic [TIME_W-1:0]       pulse_age_us;
   logic                    magnet_near;
   logic [ADC_FIELD_W-1:0]  baseline_level;

   modport source (output valid, output sample_taken, output pulse_seen,
                   output pulse_total, output pulse_period_us, output pulse_age_us,
                   output magnet_near, output baseline_level, input ready);
   modport sink   (input valid, input sample_taken, input pulse_seen,
                   input pulse_total, input pulse_period_us, input pulse_age_us,
                   input magnet_near, input baseline_level, output ready);
endinterface

`default_nettype wire

// ----- hdl/hpd_track.sv -----
// ============================================================================
// hpd_track: baseline tracking step
// Moves the Q8 baseline toward the sample by the difference divided by a
// fixed divisor, truncating toward zero (reciprocal multiply, exact).
// ============================================================================
`default_nettype none

module hpd_track import hpd_pkg::*; #(
   parameter int TRACK_DIVISOR = TRACK_DIVISOR_DEF,
   parameter int BASE_W        = ADC_FIELD_W + FRAC_W
) (
   input  wire logic [BASE_W-1:0] baseline_q8,
   input  wire logic [BASE_W-1:0] sample_fix,
   output      logic [BASE_W-1:0] baseline_next
);

   // q = (m * RECIP) >> SHIFT is exact for every m below 2^BASE_W
   localparam int SHIFT = BASE_W + $clog2(TRACK_DIVISOR);
   localparam int RECIP_W = SHIFT + 1;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(TRACK_DIVISOR) - 64'd1) / 64'(TRACK_DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int PROD_W = BASE_W + RECIP_W;

   logic [BASE_W:0]   diff;
   logic              diff_neg;
   logic [BASE_W-1:0] diff_mag;
   logic [PROD_W-1:0] prod;
   logic [BASE_W-1:0] step;

   always_comb begin
      diff     = {1'b0, sample_fix} - {1'b0, baseline_q8};
      diff_neg = diff[BASE_W];
      diff_mag = diff_neg ? BASE_W'(-diff) : diff[BASE_W-1:0];
      prod     = PROD_W'(diff_mag) * PROD_W'(RECIP);
      step     = prod[SHIFT +: BASE_W];
      // magnitude truncated first, so the sign applies toward zero
      baseline_next = diff_neg ? (baseline_q8 - step) : (baseline_q8 + step);
   end

endmodule

`default_nettype wire

// ----- hdl/hall_pulse_detector.sv -----
// ============================================================================
// hall_pulse_detector: hysteresis pulse detector with baseline tracking
// Counts magnet passes from averaged hall sensor samples and reports pulse
// count, period, age and the tracked baseline for every input beat.
// ============================================================================
// Each input beat yields exactly one result beat. A beat is registered on
// entry, evaluated combinationally by compares, wrapping time subtracts and
// the baseline tracking step (a reciprocal multiply), and lands in the result
// register together with the state update as soon as the result register is
// free or being drained. One beat is accepted every cycle while the result
// side keeps taking beats, since both registers then advance together. A
// restart beat seeds the baseline from its sample and clears counters; a
// sample beat is evaluated only when sample_period_us has elapsed since the
// last evaluated beat, otherwise it reports the current state with
// sample_taken low. Time differences wrap modulo 2^32. Configuration
// registers take effect at once and should be written only while no beat is
// in flight.
// ============================================================================
`default_nettype none

module hall_pulse_detector import hpd_pkg::*; #(
   parameter int TRACK_DIVISOR = TRACK_DIVISOR_DEF,
   parameter int ADC_BITS      = ADC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   hpd_req_if.sink                     req_bus,
   hpd_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // Only the low ADC_BITS of the sample field matter
   localparam int SAMPLE_W = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
   localparam int BASE_W   = SAMPLE_W + FRAC_W;
   localparam logic [BASE_W-1:0] ROUND_HALF = BASE_W'(1) << (FRAC_W - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [THRESH_W-1:0] trigger_delta_ff;
   logic [THRESH_W-1:0] release_delta_ff;
   logic [TIME_W-1:0]   min_interval_ff;
   logic [TIME_W-1:0]   sample_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_delta_ff <= TRIGGER_DELTA_RST;
         release_delta_ff <= RELEASE_DELTA_RST;
         min_interval_ff  <= MIN_INTERVAL_RST;
         sample_period_ff <= SAMPLE_PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TRIGGER_DELTA: trigger_delta_ff <= csr_wr_data[THRESH_W-1:0];
            CSR_RELEASE_DELTA: release_delta_ff <= csr_wr_data[THRESH_W-1:0];
            CSR_MIN_INTERVAL:  min_interval_ff  <= csr_wr_data[TIME_W-1:0];
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wr_data[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: input register feeds result register; both advance
   // together whenever the result register is free or being drained.
   // ---------------------------------------------------------------------
   logic in_valid_ff;
   logic in_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic advance;
   logic fire;
   logic req_beat;

   assign advance        = !rsp_valid_ff || rsp_bus.ready;
   assign fire           = in_valid_ff && advance;
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_beat       = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input payload register: hold until the beat moves on
   opcode_type             in_op_ff;
   logic [ADC_FIELD_W-1:0] in_sample_ff;
   logic [TIME_W-1:0]      in_time_ff;

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_op_ff     <= req_bus.opcode;
         in_sample_ff <= req_bus.adc_sample;
         in_time_ff   <= req_bus.time_us;
      end
   end

   // ---------------------------------------------------------------------
   // Detector state
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0] count_ff,       count_in;
   logic [TIME_W-1:0] last_pulse_ff,  last_pulse_in;
   logic              pulse_valid_ff, pulse_valid_in;
   logic [TIME_W-1:0] period_ff,      period_in;
   logic [TIME_W-1:0] last_sample_ff, last_sample_in;
   logic [BASE_W-1:0] baseline_ff,    baseline_in;
   logic              present_ff,     present_in;

   // Evaluation of the registered beat
   logic [SAMPLE_W-1:0] sample;
   logic [BASE_W-1:0]   sample_fix;
   logic [BASE_W-1:0]   base_sum;
   logic [SAMPLE_W-1:0] base_round;
   logic [SAMPLE_W-1:0] delta_abs;
   logic [THRESH_W-1:0] delta_ext;
   logic [TIME_W-1:0]   since_sample;
   logic [TIME_W-1:0]   since_pulse;
   logic [BASE_W-1:0]   baseline_tracked;
   logic                taken;
   logic                seen;

   assign sample     = in_sample_ff[SAMPLE_W-1:0];
   assign sample_fix = {sample, {FRAC_W{1'b0}}};
   assign base_sum   = baseline_ff + ROUND_HALF;
   assign base_round = base_sum[BASE_W-1:FRAC_W];

   hpd_track #(
      .TRACK_DIVISOR (TRACK_DIVISOR),
      .BASE_W        (BASE_W)
   ) u_track (
      .baseline_q8   (baseline_ff),
      .sample_fix    (sample_fix),
      .baseline_next (baseline_tracked)
   );

   always_comb begin
      count_in       = count_ff;
      last_pulse_in  = last_pulse_ff;
      pulse_valid_in = pulse_valid_ff;
      period_in      = period_ff;
      last_sample_in = last_sample_ff;
      baseline_in    = baseline_ff;
      present_in     = present_ff;
      taken          = 1'b0;
      seen           = 1'b0;

      delta_abs    = (sample >= base_round) ? (sample - base_round) : (base_round - sample);
      delta_ext    = THRESH_W'(delta_abs);
      since_sample = in_time_ff - last_sample_ff;
      since_pulse  = in_time_ff - last_pulse_ff;

      case (in_op_ff)
         OP_RESTART: begin
            // reseed the baseline and clear all counters
            baseline_in    = sample_fix;
            count_in       = '0;
            last_pulse_in  = '0;
            pulse_valid_in = 1'b0;
            period_in      = '0;
            last_sample_in = in_time_ff;
            present_in     = 1'b0;
            taken          = 1'b1;
         end
         OP_SAMPLE: begin
            if (since_sample >= sample_period_ff) begin
               taken          = 1'b1;
               last_sample_in = in_time_ff;
               if (present_ff) begin
                  // magnet present: wait for the release threshold
                  if (delta_ext <= release_delta_ff) begin
                     present_in = 1'b0;
                  end
               end else if (delta_ext >= trigger_delta_ff) begin
                  // entry: count only if far enough from the last pulse
                  if (!pulse_valid_ff || since_pulse >= min_interval_ff) begin
                     if (pulse_valid_ff) begin
                        period_in = since_pulse;
                     end
                     last_pulse_in  = in_time_ff;
                     pulse_valid_in = 1'b1;
                     count_in       = count_ff + TIME_W'(1);
                     seen           = 1'b1;
                  end
                  present_in = 1'b1;
               end else if (delta_ext <= release_delta_ff) begin
                  // quiet: let the baseline follow the sample
                  baseline_in = baseline_tracked;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         last_pulse_ff  <= '0;
         pulse_valid_ff <= 1'b0;
         period_ff      <= '0;
         last_sample_ff <= '0;
         baseline_ff    <= '0;
         present_ff     <= 1'b0;
      end else if (fire) begin
         count_ff       <= count_in;
         last_pulse_ff  <= last_pulse_in;
         pulse_valid_ff <= pulse_valid_in;
         period_ff      <= period_in;
         last_sample_ff <= last_sample_in;
         baseline_ff    <= baseline_in;
         present_ff     <= present_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result register: capture the updated state with the beat
   // ---------------------------------------------------------------------
   logic                taken_ff;
   logic                seen_ff;
   logic [TIME_W-1:0]   rsp_count_ff;
   logic [TIME_W-1:0]   rsp_period_ff;
   logic [TIME_W-1:0]   rsp_age_ff;
   logic [TIME_W-1:0]   rsp_age_in;
   logic                rsp_near_ff;
   logic [BASE_W-1:0]   rsp_base_ff;
   logic [BASE_W-1:0]   rsp_base_sum;

   // age is all ones until a pulse has been counted
   assign rsp_age_in = pulse_valid_in ? (in_time_ff - last_pulse_in) : '1;

   always_ff @(posedge clock) begin
      if (fire) begin
         taken_ff      <= taken;
         seen_ff       <= seen;
         rsp_count_ff  <= count_in;
         rsp_period_ff <= period_in;
         rsp_age_ff    <= rsp_age_in;
         rsp_near_ff   <= present_in;
         rsp_base_ff   <= baseline_in;
      end
   end

   // round the captured baseline to whole counts on the way out
   assign rsp_base_sum = rsp_base_ff + ROUND_HALF;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.sample_taken    = taken_ff;
   assign rsp_bus.pulse_seen      = seen_ff;
   assign rsp_bus.pulse_total     = rsp_count_ff;
   assign rsp_bus.pulse_period_us = rsp_period_ff;
   assign rsp_bus.pulse_age_us    = rsp_age_ff;
   assign rsp_bus.magnet_near     = rsp_near_ff;
   assign rsp_bus.baseline_level  = ADC_FIELD_W'(rsp_base_sum[BASE_W-1:FRAC_W]);

endmodule

`default_nettype wire

// ----- verif/hpd_result_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hpd_result_checker: result predictor and comparator for the pulse detector
// Mirrors the register writes and every accepted input beat into its own
// model of the detector and compares each result beat, field by field,
// with the oldest expected report.
// ============================================================================

module hpd_result_checker import hpd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   hpd_req_if                          req_bus,
   hpd_rsp_if                          rsp_bus,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   output int                          fail_count,
   output int                          pending_beats,
   output int                          checked_beats
);

   localparam int TRACK_DIV = TRACK_DIVISOR_DEF;
   localparam int ADC_MASK  = (1 << ADC_BITS_DEF) - 1;

   typedef struct packed {
      logic                   taken;
      logic                   seen;
      logic [TIME_W-1:0]      total;
      logic [TIME_W-1:0]      period;
      logic [TIME_W-1:0]      age;
      logic                   near;
      logic [ADC_FIELD_W-1:0] level;
   } hall_report_type;

   // Register copies
   logic [THRESH_W-1:0] trigger_th;
   logic [THRESH_W-1:0] release_th;
   logic [TIME_W-1:0]   min_gap_us;
   logic [TIME_W-1:0]   sample_gap_us;

   // Detector state
   logic [TIME_W-1:0]   pulse_count;
   logic [TIME_W-1:0]   last_pulse_at;
   logic [TIME_W-1:0]   period_us;
   logic [TIME_W-1:0]   last_taken_at;
   logic                pulse_known;
   logic                magnet_flag;
   int                  base_q8;

   hall_report_type     expected_reports[$];
   int                  errors = 0;
   int                  done = 0;

   // Baseline in whole ADC counts, rounded half up
   function automatic int rounded_level();
      return (base_q8 + 128) >>> FRAC_W;
   endfunction

   // Update the detector state for one input beat and report what it shows
   function automatic hall_report_type advance_detector(opcode_type op,
                                                        logic [ADC_FIELD_W-1:0] raw,
                                                        logic [TIME_W-1:0] now);
      hall_report_type   r;
      int                reading;
      int                level;
      int                distance;
      int                track_step;
      logic [TIME_W-1:0] since;
      r = '0;
      reading = int'(raw) & ADC_MASK;
      since = now - last_taken_at;
      if (op == OP_RESTART) begin
         base_q8       = reading << FRAC_W;
         pulse_count   = '0;
         last_pulse_at = '0;
         pulse_known   = 1'b0;
         period_us     = '0;
         last_taken_at = now;
         magnet_flag   = 1'b0;
         r.taken       = 1'b1;
      end else if (since >= sample_gap_us) begin
         level = rounded_level();
         distance = (reading >= level) ? reading - level : level - reading;
         r.taken = 1'b1;
         last_taken_at = now;
         if (magnet_flag) begin
            if (distance <= int'(release_th))
               magnet_flag = 1'b0;
         end else if (distance >= int'(trigger_th)) begin
            since = now - last_pulse_at;
            if (!pulse_known || since >= min_gap_us) begin
               if (pulse_known)
                  period_us = since;
               last_pulse_at = now;
               pulse_known   = 1'b1;
               pulse_count   = pulse_count + 1;
               r.seen        = 1'b1;
            end
            magnet_flag = 1'b1;
         end else if (distance <= int'(release_th)) begin
            // signed division truncates toward zero
            track_step = ((reading << FRAC_W) - base_q8) / TRACK_DIV;
            base_q8 = base_q8 + track_step;
         end
      end
      r.total  = pulse_count;
      r.period = period_us;
      r.age    = pulse_known ? now - last_pulse_at : '1;
      r.near   = magnet_flag;
      r.level  = ADC_FIELD_W'(rounded_level());
      return r;
   endfunction

   task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      hall_report_type want;
      if (reset) begin
         trigger_th    = TRIGGER_DELTA_RST;
         release_th    = RELEASE_DELTA_RST;
         min_gap_us    = MIN_INTERVAL_RST;
         sample_gap_us = SAMPLE_PERIOD_RST;
         pulse_count   = '0;
         last_pulse_at = '0;
         period_us     = '0;
         last_taken_at = '0;
         pulse_known   = 1'b0;
         magnet_flag   = 1'b0;
         base_q8       = 0;
         expected_reports.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TRIGGER_DELTA: trigger_th    = csr_wr_data[THRESH_W-1:0];
               CSR_RELEASE_DELTA: release_th    = csr_wr_data[THRESH_W-1:0];
               CSR_MIN_INTERVAL:  min_gap_us    = csr_wr_data;
               CSR_SAMPLE_PERIOD: sample_gap_us = csr_wr_data;
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_reports.size() == 0) begin
               $display("%0t: result beat with no expectation, expected none, got total %0h",
                        $time, rsp_bus.pulse_total);
               errors++;
            end else begin
               want = expected_reports.pop_front();
               check_field("sample_taken", want.taken, rsp_bus.sample_taken);
               check_field("pulse_seen", want.seen, rsp_bus.pulse_seen);
               check_field("pulse_total", want.total, rsp_bus.pulse_total);
               check_field("pulse_period_us", want.period, rsp_bus.pulse_period_us);
               check_field("pulse_age_us", want.age, rsp_bus.pulse_age_us);
               check_field("magnet_near", want.near, rsp_bus.magnet_near);
               check_field("baseline_level", want.level, rsp_bus.baseline_level);
               done++;
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_reports.push_back(advance_detector(req_bus.opcode, req_bus.adc_sample,
                                                        req_bus.time_us));
      end
      fail_count    <= errors;
      pending_beats <= expected_reports.size();
      checked_beats <= done;
   end

endmodule

// ----- verif/hall_pulse_detector_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// hall_pulse_detector_tb: stimulus and verdict for the hall pulse detector
// Drives directed corner beats under the reset, lowest and highest register
// settings, then well-formed magnet-pass sequences with noise under the reset
// settings and several random ones. Both channel sides idle at random; one
// phase holds the result side off for a long stretch. The checker beside the
// block judges every result beat.
// ============================================================================

module hall_pulse_detector_tb;
   import hpd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 120;
   localparam int SEQ_BEATS   = 110;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   int                     fail_count;
   int                     pending_beats;
   int                     checked_beats;
   int                     cycles = 0;
   int                     beats_sent = 0;
   int                     settings_used = 0;

   // steady_flow: no idling on either side; hold_wanted: one long result stall
   bit                     steady_flow = 1'b0;
   bit                     hold_wanted = 1'b0;

   // Running microsecond time of the stimulus and nominal rest level of the sensor
   logic [TIME_W-1:0]      clock_us;
   int                     rest_level;

   hpd_req_if req_bus ();
   hpd_rsp_if rsp_bus ();

   hall_pulse_detector u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   hpd_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_beats (pending_beats),
      .checked_beats (checked_beats)
   );

   always #2 clock = ~clock;

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: watchdog expired with %0d beats outstanding", $time, pending_beats);
         $display("FAILURE");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_adc(int v);
      if (v < 0)
         return 0;
      if (v > 1023)
         return 1023;
      return v;
   endfunction

   // Offer one beat and hold it until the block takes it; valid stays high on return
   task automatic send_beat(opcode_type op, int reading, logic [TIME_W-1:0] at);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.adc_sample <= reading[ADC_FIELD_W-1:0];
      req_bus.time_us    <= at;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only with the block idle
   task automatic configure(logic [CSR_DATA_W-1:0] trig, logic [CSR_DATA_W-1:0] rel,
                            logic [CSR_DATA_W-1:0] min_gap, logic [CSR_DATA_W-1:0] period);
      drain();
      write_reg(CSR_TRIGGER_DELTA, trig);
      write_reg(CSR_RELEASE_DELTA, rel);
      write_reg(CSR_MIN_INTERVAL, min_gap);
      write_reg(CSR_SAMPLE_PERIOD, period);
      settings_used++;
   endtask

   // Restart, then alternate quiet stretches near the rest level with short
   // magnet passes; mix in occasional restarts and fully random noise beats.
   task automatic run_sequence(int beats, int trig, int rel, int period);
      int quiet_left;
      int pass_left;
      int reading;
      int offset;
      int roll;
      int n;
      rest_level = $urandom_range(0, 1023);
      clock_us = $urandom;
      send_beat(OP_RESTART, rest_level, clock_us);
      quiet_left = $urandom_range(2, 12);
      pass_left = 0;
      for (n = 1; n < beats; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            rest_level = $urandom_range(0, 1023);
            clock_us += $urandom_range(0, 3 * period + 100);
            send_beat(OP_RESTART, rest_level, clock_us);
         end else if (roll < 12) begin
            send_beat(OP_SAMPLE, $urandom_range(0, 1023), $urandom);
         end else begin
            // advance time: mostly just past the sample period, some too early, some long
            roll = $urandom_range(0, 99);
            if (roll < 75)
               clock_us += period + $urandom_range(0, period / 8 + 40);
            else if (roll < 90)
               clock_us += $urandom_range(0, period);
            else
               clock_us += $urandom_range(period, 20 * period + 5000);
            if (pass_left > 0) begin
               offset = trig + $urandom_range(0, 60);
               reading = clamp_adc(rest_level >= 512 ? rest_level - offset : rest_level + offset);
               pass_left--;
               if (pass_left == 0)
                  quiet_left = $urandom_range(2, 12);
            end else begin
               offset = rel + 3;
               reading = clamp_adc(rest_level + $urandom_range(0, 2 * offset) - offset);
               quiet_left--;
               if (quiet_left == 0)
                  pass_left = $urandom_range(1, 4);
            end
            send_beat(OP_SAMPLE, reading, clock_us);
         end
      end
   endtask

   // Result side: random ready with an occasional long hold-off on request
   initial begin : rsp_side
      int gap;
      forever begin
         if (hold_wanted) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_wanted = 1'b0;
         end else begin
            gap = steady_flow ? 0 : pick_gap();
            if (gap == 0) begin
               rsp_bus.ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int trig;
      int rel;
      int min_gap;
      int period;
      int k;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_SAMPLE;
      req_bus.adc_sample <= '0;
      req_bus.time_us    <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= CSR_TRIGGER_DELTA;
      csr_wr_data        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // ---- reset settings: trigger 100, release 50, interval 10000, period 1000
      // sample before any restart at time zero is skipped; age reads all ones
      send_beat(OP_SAMPLE, 512, 32'd0);
      // restart near the top of the time range, next sample wraps past zero
      send_beat(OP_RESTART, 1023, 32'hFFFF_FF00);
      clock_us = 32'h0000_0300;
      send_beat(OP_SAMPLE, 1023, clock_us);
      // first pulse sets no period
      clock_us += 1000;
      send_beat(OP_SAMPLE, 0, clock_us);
      // too early: skipped
      clock_us += 500;
      send_beat(OP_SAMPLE, 0, clock_us);
      // release, then a pass too soon after the last pulse: near but not counted
      clock_us += 1000;
      send_beat(OP_SAMPLE, 1000, clock_us);
      clock_us += 1000;
      send_beat(OP_SAMPLE, 0, clock_us);
      clock_us += 1000;
      send_beat(OP_SAMPLE, 1023, clock_us);
      clock_us += 12000;
      send_beat(OP_SAMPLE, 0, clock_us);
      // pulse at time zero counts as a real pulse
      send_beat(OP_RESTART, 512, 32'hFFFF_FC18);
      send_beat(OP_SAMPLE, 1023, 32'd0);
      send_beat(OP_SAMPLE, 512, 32'd1000);
      // track down, track up, then a distance inside the hysteresis band
      send_beat(OP_SAMPLE, 500, 32'd2000);
      send_beat(OP_SAMPLE, 560, 32'd3000);
      send_beat(OP_SAMPLE, 600, 32'd4000);
      // exactly the minimum interval after the pulse at zero
      send_beat(OP_SAMPLE, 0, 32'd10000);

      // ---- lowest settings: every beat taken, every entry counted, exact release
      configure(0, 0, 0, 0);
      send_beat(OP_RESTART, 300, 32'd5);
      send_beat(OP_SAMPLE, 300, 32'd5);
      send_beat(OP_SAMPLE, 300, 32'd5);
      send_beat(OP_SAMPLE, 301, 32'd5);
      send_beat(OP_SAMPLE, 900, 32'd6);
      send_beat(OP_SAMPLE, 300, 32'd6);

      // ---- highest settings: only a full wrap of time passes the sample period
      configure(1023, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_RESTART, 0, 32'd100);
      send_beat(OP_SAMPLE, 1023, 32'd99);
      send_beat(OP_SAMPLE, 0, 32'd500);
      send_beat(OP_RESTART, 1023, 32'hFFFF_FFFF);
      send_beat(OP_SAMPLE, 0, 32'hFFFF_FFFE);
      send_beat(OP_SAMPLE, 0, 32'hFFFF_FFFD);

      // ---- back to reset values with no idling; stall the result side long
      // enough that the block fills up and stops taking input
      configure(TRIGGER_DELTA_RST, RELEASE_DELTA_RST, MIN_INTERVAL_RST, SAMPLE_PERIOD_RST);
      steady_flow = 1'b1;
      hold_wanted = 1'b1;
      run_sequence(SEQ_BEATS, int'(TRIGGER_DELTA_RST), int'(RELEASE_DELTA_RST),
                   int'(SAMPLE_PERIOD_RST));
      steady_flow = 1'b0;

      // ---- random settings
      for (k = 0; k < 4; k++) begin
         trig    = $urandom_range(10, 250);
         rel     = $urandom_range(0, trig + 20);
         min_gap = $urandom_range(0, 20000);
         period  = $urandom_range(0, 2000);
         configure(trig, rel, min_gap, period);
         run_sequence(SEQ_BEATS, trig, rel, period);
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Drove %0d input beats over %0d register settings; %0d results checked.",
               beats_sent, settings_used, checked_beats);
      if (fail_count == 0 && pending_beats == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/hpd_pkg.sv
hdl/hpd_req_if.sv
hdl/hpd_rsp_if.sv
hdl/hpd_track.sv
hdl/hall_pulse_detector.sv
verif/hpd_result_checker.sv
verif/hall_pulse_detector_tb.sv
